FILE: src/streaming_logit_argmax_unit_defines.svh
// Assertion macros for the logit argmax unit.
`ifndef STREAMING_LOGIT_ARGMAX_UNIT_DEFINES_SVH
`define STREAMING_LOGIT_ARGMAX_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SLA_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define SLA_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define SLA_ASSERT_IMPL(label, a, c)
`define SLA_ASSERT_NEXT(label, a, c)
`endif
`endif

FILE: src/sla_pkg.sv
`timescale 1ns / 1ps
package sla_pkg;
	localparam int unsigned MAX_ELEMENTS = 65536;
	localparam int IDX_W = 16;
	localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_ELEMENTS - 1);
	localparam logic [31:0] NEG_INF_BITS = 32'hFF800000;
	localparam logic FMT_SINGLE = 1'b0;
	localparam logic FMT_HALF = 1'b1;

	function automatic logic [31:0] order_key(input logic [31:0] f);
		logic [31:0] g;
		g = (f[30:0] == 31'd0) ? 32'd0 : f;
		return g[31] ? ~g : (g | 32'h80000000);
	endfunction
endpackage

FILE: src/sla_widen.sv
`timescale 1ns / 1ps
module sla_widen (
	input  logic [31:0] raw,
	input  logic        fmt,
	output logic [31:0] value,
	output logic        is_nan
);
	import sla_pkg::*;
	logic [4:0]  expo;
	logic [9:0]  mant;
	logic [3:0]  lz;
	logic [9:0]  norm;
	logic [31:0] half;

	always_comb begin
		expo = raw[14:10];
		mant = raw[9:0];
		lz = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (mant[i]) begin
				lz = 4'(9 - i);
			end
		end
		norm = 10'(mant << (lz + 4'd1));
		if (expo == 5'd0) begin
			if (mant == 10'd0) begin
				half = {raw[15], 31'd0};
			end else begin
				half = {raw[15], 8'(8'd112 - 8'(lz)), norm, 13'd0};
			end
		end else if (expo == 5'd31) begin
			half = {raw[15], 8'hFF, mant, 13'd0};
		end else begin
			half = {raw[15], 8'(8'(expo) + 8'd112), mant, 13'd0};
		end
		value = (fmt == FMT_HALF) ? half : raw;
		is_nan = (value[30:23] == 8'hFF) && (value[22:0] != 23'd0);
	end
endmodule

FILE: src/streaming_logit_argmax_unit.sv
// Channel  Dir  Word
// s_axis   in   tdata[31:0] logit_bits, tlast last_element
// m_axis   out  tdata[15:0] best_index
// cfg      in   element_format, single write enable
// One word per cycle while not stalled: input register, widening and compare, result register.
// The result word is registered once the last word sits in the input register and no unaccepted result word holds it.
// Reset clears format, state and valids.
// Input stalls only while a last word waits behind an unaccepted result word.
`timescale 1ns / 1ps
`include "streaming_logit_argmax_unit_defines.svh"
module streaming_logit_argmax_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // logit_bits
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // best_index
);
	import sla_pkg::*;
	logic        fmt_q, v_s1, last_s1, nan_w;
	logic [31:0] data_s1, val_w, best_q;
	logic [15:0] pos_q, cnt_q;
	logic        adv, win, stall;

	assign stall = v_s1 && last_s1 && m_axis_tvalid && !m_axis_tready;
	assign adv = !stall;
	assign s_axis_tready = adv;

	sla_widen u_widen (.raw(data_s1), .fmt(fmt_q), .value(val_w), .is_nan(nan_w));
	assign win = !nan_w && (order_key(val_w) > order_key(best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_SINGLE;
			v_s1 <= 1'b0;
			best_q <= NEG_INF_BITS;
			pos_q <= '0;
			cnt_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
		end else begin
			if (cfg_we) fmt_q <= cfg_wdata;
			if (adv && v_s1 && last_s1) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			if (adv) begin
				v_s1 <= s_axis_tvalid;
				if (v_s1) begin
					if (last_s1) begin
						m_axis_tdata <= win ? cnt_q : pos_q;
						best_q <= NEG_INF_BITS;
						pos_q <= '0;
						cnt_q <= '0;
					end else begin
						if (win) begin
							best_q <= val_w;
							pos_q <= cnt_q;
						end
						if (cnt_q < IDX_LIMIT) cnt_q <= cnt_q + 16'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	`SLA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`SLA_ASSERT_IMPL(a_cnt, 1'b1, cnt_q <= IDX_LIMIT)
	`SLA_ASSERT_IMPL(a_pos, 1'b1, pos_q <= cnt_q)
endmodule
